FILE: hdl/assert_macros.svh
// Assertion helpers for the archive decryptor RTL.
// All checks sample on posedge clk and are off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge
`define AEBD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// When pre holds, post must hold in the next cycle
`define AEBD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AEBD_ASSERT(lbl, expr, msg)
`define AEBD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: hdl/aebd_pkg.sv
package aebd_pkg;

  localparam int unsigned KEY_BYTES  = 16;
  localparam int unsigned POS_W      = 4;
  localparam int unsigned WARM_W     = 3;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned CHAIN_LEN  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Warm-up saturates once the chaining history is full
  localparam logic [WARM_W-1:0] WARM_FULL = WARM_W'(CHAIN_LEN);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_CHAIN_MODE = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       entry_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       plain_end;
  } out_item_t;

  // Key byte n of the 128-bit key, byte 0 in the low bits
  function automatic logic [7:0] key_byte(input logic [8*KEY_BYTES-1:0] key,
                                          input logic [POS_W-1:0] idx);
    key_byte = key[{idx, 3'b000} +: 8];
  endfunction

endpackage

FILE: hdl/aebd_in_if.sv
interface aebd_in_if
  import aebd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_byte;
  logic       entry_end;

  modport source (output valid, output cipher_byte, output entry_end, input ready);
  modport sink   (input valid, input cipher_byte, input entry_end, output ready);
endinterface

FILE: hdl/aebd_out_if.sv
interface aebd_out_if
  import aebd_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] plain_byte;
  logic       plain_end;

  modport source (output valid, output plain_byte, output plain_end, input ready);
  modport sink   (input valid, input plain_byte, input plain_end, output ready);
endinterface

FILE: hdl/archive_entry_byte_decryptor.sv
// Streaming archive-entry byte decryptor. Each byte is XORed with key byte
// (position mod 16); with chain_mode set it is also XORed with the first four
// key bytes during an entry's first four bytes and afterwards with the cipher
// byte four positions back. entry_end restarts position and warm-up. Throughput
// is one byte per clock while the output is not stalled. Each result passes
// through the input register, then the result register, before it is offered
// on the output. While a result waits, the input register can still take one
// more item; after that input ready drops until the result is taken.
// Write configuration only while the block is empty.
module archive_entry_byte_decryptor
  import aebd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  aebd_in_if.sink               in_ch,
  aebd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      s1_valid;
  in_item_t  s1_item;
  out_item_t result;
  logic      out_free;
  logic      adv;

  // Held item moves into the result register
  assign adv = s1_valid && out_free;

  aebd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  aebd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .adv       (adv),
    .s1_item   (s1_item),
    .result    (result)
  );

  aebd_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .s1_valid (s1_valid),
    .result   (result),
    .out_free (out_free)
  );

endmodule

FILE: hdl/aebd_in_stage.sv
// Input register: captures one transaction per cycle while ready, holds it until adv
module aebd_in_stage
  import aebd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  aebd_in_if.sink       in_ch,
  input  logic          adv,
  output logic          s1_valid,
  output in_item_t      s1_item
);

  logic     valid_r;
  in_item_t item_r;

  // Free when empty or when the held item moves on this cycle
  assign in_ch.ready = !valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.cipher_byte <= in_ch.cipher_byte;
      item_r.entry_end   <= in_ch.entry_end;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: hdl/aebd_core.sv
`include "assert_macros.svh"
// Key/chaining state, configuration registers and the per-byte XOR
module aebd_core
  import aebd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  adv,
  input  in_item_t              s1_item,
  output out_item_t             result
);

  logic [CFG_DATA_W-1:0] key_low_r;
  logic [CFG_DATA_W-1:0] key_high_r;
  logic                  chain_mode_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [WARM_W-1:0] warm_r, warm_nxt;
  logic [7:0]        hist_r [CHAIN_LEN];

  logic [SLOT_W-1:0] slot;
  logic [7:0]        kb;
  logic [7:0]        chain;
  logic              warm_done;

  // Configuration writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      chain_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LOW:    key_low_r    <= cfg_wdata;
        CFG_KEY_HIGH:   key_high_r   <= cfg_wdata;
        CFG_CHAIN_MODE: chain_mode_r <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  // Datapath: key byte, then chaining byte (key during warm-up, else history)
  assign slot      = pos_r[SLOT_W-1:0];
  assign kb        = key_byte({key_high_r, key_low_r}, pos_r);
  assign warm_done = (warm_r == WARM_FULL);
  assign chain     = warm_done ? hist_r[slot] : kb;

  assign result.plain_byte = s1_item.cipher_byte ^ kb ^ (chain_mode_r ? chain : 8'h00);
  assign result.plain_end  = s1_item.entry_end;

  // Counters restart after the entry's last byte
  always_comb begin
    if (s1_item.entry_end) begin
      pos_nxt  = '0;
      warm_nxt = '0;
    end else begin
      pos_nxt  = pos_r + POS_W'(1);
      warm_nxt = warm_done ? warm_r : warm_r + WARM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      warm_r <= '0;
    end else if (adv) begin
      pos_r  <= pos_nxt;
      warm_r <= warm_nxt;
    end
  end

  // History is updated in both modes; no reset needed
  always_ff @(posedge clk) begin
    if (adv) begin
      hist_r[slot] <= s1_item.cipher_byte;
    end
  end

  `AEBD_ASSERT(a_warm_sat, warm_r <= WARM_FULL, "warm-up count above saturation")
  `AEBD_ASSERT_NEXT(a_end_restart, adv && s1_item.entry_end, pos_r == '0 && warm_r == '0, "counters not cleared after entry end")
  `AEBD_ASSERT_NEXT(a_pos_step, adv && !s1_item.entry_end, pos_r == POS_W'($past(pos_r) + POS_W'(1)), "key position did not advance")

endmodule

FILE: hdl/aebd_out_stage.sv
// Result register: loads a new byte whenever it is empty or being drained
module aebd_out_stage
  import aebd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  aebd_out_if.source    out_ch,
  input  logic          s1_valid,
  input  out_item_t     result,
  output logic          out_free
);

  logic      valid_r;
  out_item_t item_r;

  assign out_free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      item_r <= result;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.plain_byte = item_r.plain_byte;
  assign out_ch.plain_end  = item_r.plain_end;

endmodule
